// ----- sv/phase_shift_graycode_unwrap_macros.svh -----
// Assertion macros shared by the phase unwrap checker
`ifndef PHASE_SHIFT_GRAYCODE_UNWRAP_MACROS_SVH
`define PHASE_SHIFT_GRAYCODE_UNWRAP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PSGU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PSGU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/psgu_pkg.sv -----
// Shared types, widths and constants of the phase shift gray-code unwrap pipeline
package psgu_pkg;

   localparam int SAMPLE_W      = 8;
   localparam int PHASE_COUNT   = 4;
   localparam int GRAY_COUNT    = 6;
   localparam int IN_FIELDS     = PHASE_COUNT + GRAY_COUNT;
   localparam int REQ_DATA_W    = IN_FIELDS * SAMPLE_W;
   localparam int SUM_W         = 10;
   localparam int DIFF_W        = SAMPLE_W + 1;

   localparam int CORDIC_STEPS  = 20;
   localparam int CORDIC_FRAC   = 20;
   localparam int PHASE_FRAC    = 12;
   localparam int ROUND_SHIFT   = CORDIC_FRAC - PHASE_FRAC;
   localparam int INPUT_SCALE   = 24;
   localparam int CORDIC_W      = 36;
   localparam int Z_W           = 24;
   localparam int TH_W          = Z_W - ROUND_SHIFT;

   localparam int WRAP_W        = 15;
   localparam int FLOOR_W       = 7;
   localparam int UNW_W         = 21;
   localparam int PROD_W        = UNW_W + 1;
   localparam int K1_W          = GRAY_COUNT - 1;
   localparam int K2_W          = GRAY_COUNT;
   localparam int RSP_FIELDS_W  = WRAP_W + FLOOR_W + UNW_W + 1;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic signed [Z_W-1:0]    PI_Q20    = 24'sd3294199;
   localparam logic signed [TH_W-1:0]   PI_F      = 16'sd12868;
   localparam logic signed [TH_W-1:0]   HALF_PI_F = 16'sd6434;
   localparam logic signed [PROD_W-1:0] TWO_PI_F  = 22'sd25736;
   localparam logic signed [FLOOR_W-1:0] FLOOR_MIN = -7'sd1;
   localparam logic signed [FLOOR_W-1:0] FLOOR_MAX = 7'sd32;

   localparam logic signed [Z_W-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
      24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
      24'sd32757,  24'sd16383,  24'sd8192,   24'sd4096,   24'sd2048,
      24'sd1024,   24'sd512,    24'sd256,    24'sd128,    24'sd64,
      24'sd32,     24'sd16,     24'sd8,      24'sd4,      24'sd2
   };

   // Per-pixel results that ride alongside the rotation
   typedef struct packed {
      logic              zero_vec;
      logic              pix_valid;
      logic [K1_W-1:0]   k1;
      logic [K2_W-1:0]   k2;
   } side_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [Z_W-1:0]      z;
      side_type                   side;
   } cordic_type;

endpackage

// ----- sv/psgu_front.sv -----
// Input stage: threshold register, sums, gray decode and CORDIC pre-rotation
module psgu_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [psgu_pkg::SAMPLE_W-1:0]      csr_wr_data,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [psgu_pkg::REQ_DATA_W-1:0]    in_data,
   output logic                               out_valid,
   input  logic                               out_ready,
   output psgu_pkg::cordic_type               out_data
);

   logic [psgu_pkg::SAMPLE_W-1:0]     thr_ff;
   logic                              valid_ff;
   psgu_pkg::cordic_type              data_ff;
   psgu_pkg::cordic_type              data_in;
   logic                              adv;

   logic [psgu_pkg::SAMPLE_W-1:0]     smp [0:psgu_pkg::IN_FIELDS-1];
   logic signed [psgu_pkg::DIFF_W-1:0] dif_d, dif_m, xs, ys;
   logic [psgu_pkg::SUM_W-1:0]        sum;
   logic [psgu_pkg::GRAY_COUNT-1:0]   tbit;
   logic [psgu_pkg::K2_W:0]           k2_full;

   // Hold the confidence threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 8'd5;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // Split the packed samples
   always_comb begin
      for (int k = 0; k < psgu_pkg::IN_FIELDS; k++) begin
         smp[k] = in_data[k*psgu_pkg::SAMPLE_W +: psgu_pkg::SAMPLE_W];
      end
   end

   // Form sums, gray bits and the pre-rotated vector
   always_comb begin
      logic t;
      dif_d = $signed({1'b0, smp[0]}) - $signed({1'b0, smp[2]});
      dif_m = $signed({1'b0, smp[1]}) - $signed({1'b0, smp[3]});
      sum   = {2'b00, smp[0]} + {2'b00, smp[1]} + {2'b00, smp[2]} + {2'b00, smp[3]};

      t = 1'b0;
      for (int k = 0; k < psgu_pkg::GRAY_COUNT; k++) begin
         t = t ^ ({smp[psgu_pkg::PHASE_COUNT + k], 2'b00} > sum);
         tbit[psgu_pkg::GRAY_COUNT-1-k] = t;
      end
      k2_full = {1'b0, tbit} + 7'd1;

      // Flip into the right half plane when x is negative
      xs = dif_d[psgu_pkg::DIFF_W-1] ? -dif_d : dif_d;
      ys = dif_d[psgu_pkg::DIFF_W-1] ? -dif_m : dif_m;

      data_in.x = {{(psgu_pkg::CORDIC_W-psgu_pkg::DIFF_W-psgu_pkg::INPUT_SCALE){xs[8]}},
                   xs, {psgu_pkg::INPUT_SCALE{1'b0}}};
      data_in.y = {{(psgu_pkg::CORDIC_W-psgu_pkg::DIFF_W-psgu_pkg::INPUT_SCALE){ys[8]}},
                   ys, {psgu_pkg::INPUT_SCALE{1'b0}}};
      if (!dif_d[psgu_pkg::DIFF_W-1]) begin
         data_in.z = '0;
      end else if (!dif_m[psgu_pkg::DIFF_W-1]) begin
         data_in.z = psgu_pkg::PI_Q20;
      end else begin
         data_in.z = -psgu_pkg::PI_Q20;
      end

      data_in.side.zero_vec  = (dif_d == '0) && (dif_m == '0);
      data_in.side.pix_valid = sum > {thr_ff, 2'b00};
      data_in.side.k1        = tbit[psgu_pkg::GRAY_COUNT-1:1];
      data_in.side.k2        = k2_full[psgu_pkg::K2_W:1];
   end

   // Advance when the stage is empty or drains
   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- sv/psgu_cordic.sv -----
// Vectoring CORDIC, one micro-rotation per pipeline stage
module psgu_cordic (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  psgu_pkg::cordic_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output psgu_pkg::cordic_type  out_data
);

   localparam int N = psgu_pkg::CORDIC_STEPS;

   psgu_pkg::cordic_type st_ff  [0:N-1];
   psgu_pkg::cordic_type st_in  [0:N-1];
   psgu_pkg::cordic_type src    [0:N-1];
   logic                 vld_ff [0:N-1];
   logic                 vsrc   [0:N-1];
   logic [N:0]           rdy;

   assign rdy[N] = out_ready;

   for (genvar i = 0; i < N; i++) begin : g_step
      if (i == 0) begin : g_first
         assign src[i]  = in_data;
         assign vsrc[i] = in_valid;
      end else begin : g_next
         assign src[i]  = st_ff[i-1];
         assign vsrc[i] = vld_ff[i-1];
      end

      // Rotate toward the x axis by atan(2^-i)
      always_comb begin
         logic signed [psgu_pkg::CORDIC_W-1:0] xc, yc, dx, dy;
         logic signed [psgu_pkg::Z_W-1:0]      zc;
         xc = src[i].x;
         yc = src[i].y;
         zc = src[i].z;
         dx = yc >>> i;
         dy = xc >>> i;
         st_in[i] = src[i];
         if (!yc[psgu_pkg::CORDIC_W-1]) begin
            st_in[i].x = xc + dx;
            st_in[i].y = yc - dy;
            st_in[i].z = zc + psgu_pkg::ATAN_TAB[i];
         end else begin
            st_in[i].x = xc - dx;
            st_in[i].y = yc + dy;
            st_in[i].z = zc - psgu_pkg::ATAN_TAB[i];
         end
      end

      // Advance when this stage is empty or the next one takes it
      assign rdy[i] = !vld_ff[i] || rdy[i+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            vld_ff[i] <= vsrc[i];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[N-1];
   assign out_data  = st_ff[N-1];

endmodule

// ----- sv/psgu_back.sv -----
// Output stages: phase rounding, fringe order select and absolute phase
module psgu_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  psgu_pkg::cordic_type                  in_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [psgu_pkg::WRAP_W-1:0]    wrapped_phase,
   output logic signed [psgu_pkg::FLOOR_W-1:0]   floor_index,
   output logic signed [psgu_pkg::UNW_W-1:0]     unwrapped_phase,
   output logic                                  pixel_valid
);

   // Stage 1: rounded wrapped phase
   logic                                 v1_ff;
   logic signed [psgu_pkg::WRAP_W-1:0]   ph1_ff, ph1_in;
   psgu_pkg::side_type                   sd1_ff;
   // Stage 2: fringe order and its scaled product
   logic                                 v2_ff;
   logic signed [psgu_pkg::WRAP_W-1:0]   ph2_ff;
   logic signed [psgu_pkg::FLOOR_W-1:0]  fl2_ff, fl2_in;
   logic signed [psgu_pkg::PROD_W-1:0]   pr2_ff, pr2_in;
   logic                                 pv2_ff;
   // Stage 3: result register
   logic                                 v3_ff;
   logic signed [psgu_pkg::WRAP_W-1:0]   ph3_ff;
   logic signed [psgu_pkg::FLOOR_W-1:0]  fl3_ff;
   logic signed [psgu_pkg::UNW_W-1:0]    un3_ff, un3_in;
   logic                                 pv3_ff;

   logic adv1, adv2, adv3;

   assign adv3 = !v3_ff || out_ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign in_ready = adv1;

   // Round to output precision, clamp to +-pi (zero for a zero vector) and negate
   always_comb begin
      logic signed [psgu_pkg::Z_W-1:0]  zr;
      logic signed [psgu_pkg::TH_W-1:0] th;
      zr = in_data.z + psgu_pkg::Z_W'(1 << (psgu_pkg::ROUND_SHIFT - 1));
      th = zr[psgu_pkg::Z_W-1:psgu_pkg::ROUND_SHIFT];
      if (in_data.side.zero_vec) begin
         th = '0;
      end else if (th > psgu_pkg::PI_F) begin
         th = psgu_pkg::PI_F;
      end else if (th < -psgu_pkg::PI_F) begin
         th = -psgu_pkg::PI_F;
      end
      ph1_in = psgu_pkg::WRAP_W'(-th);
   end

   // Pick the fringe order by which quarter the phase sits in
   always_comb begin
      logic signed [psgu_pkg::TH_W-1:0] ph;
      ph = psgu_pkg::TH_W'(ph1_ff);
      if (ph <= -psgu_pkg::HALF_PI_F) begin
         fl2_in = $signed({1'b0, sd1_ff.k2});
      end else if (ph >= psgu_pkg::HALF_PI_F) begin
         fl2_in = $signed({1'b0, sd1_ff.k2}) - 7'sd1;
      end else begin
         fl2_in = $signed({2'b00, sd1_ff.k1});
      end
      pr2_in = psgu_pkg::PROD_W'(fl2_in) * psgu_pkg::TWO_PI_F;
   end

   // Sum into the absolute phase, zero for dim pixels
   always_comb begin
      logic signed [psgu_pkg::PROD_W-1:0] acc;
      acc = psgu_pkg::PROD_W'(ph2_ff) + pr2_ff + psgu_pkg::PROD_W'(psgu_pkg::PI_F);
      un3_in = pv2_ff ? acc[psgu_pkg::UNW_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         ph1_ff <= ph1_in;
         sd1_ff <= in_data.side;
      end
      if (adv2) begin
         ph2_ff <= ph1_ff;
         fl2_ff <= fl2_in;
         pr2_ff <= pr2_in;
         pv2_ff <= sd1_ff.pix_valid;
      end
      if (adv3) begin
         ph3_ff <= ph2_ff;
         fl3_ff <= fl2_ff;
         un3_ff <= un3_in;
         pv3_ff <= pv2_ff;
      end
   end

   assign out_valid       = v3_ff;
   assign wrapped_phase   = ph3_ff;
   assign floor_index     = fl3_ff;
   assign unwrapped_phase = un3_ff;
   assign pixel_valid     = pv3_ff;

endmodule

// ----- sv/phase_shift_graycode_unwrap.sv -----
// Top level of the four-step phase shift, gray-code unwrap pipeline
// Takes one pixel per clock while results are taken (four phase samples, six gray
// samples) and returns one result per pixel through its register stages: one
// input stage, twenty CORDIC micro-rotation stages and three output stages.
// Throughput is one pixel per clock; each stage advances whenever it is empty or
// its successor takes its contents, so a stalled result only holds the stages
// that are full. Write csr_wr_data (confidence threshold, reset 5) only while no
// pixels are in flight.
module phase_shift_graycode_unwrap (
   input  logic                                 clock,
   input  logic                                 reset,
   // Confidence threshold write
   input  logic                                 csr_wr_en,
   input  logic [psgu_pkg::SAMPLE_W-1:0]        csr_wr_data,
   // Pixel input
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // phase_sample_0..3, then gray_sample_0..5, 8 bits each, from bit 0 up
   input  logic [psgu_pkg::REQ_DATA_W-1:0]      req_tdata,
   // Result output
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // wrapped_phase[14:0], floor_index[21:15], unwrapped_phase[42:22],
   // pixel_valid[43], zero fill [47:44]
   output logic [psgu_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   psgu_pkg::cordic_type front_data, cordic_data;
   logic front_valid, front_ready, cordic_valid, cordic_ready;

   logic signed [psgu_pkg::WRAP_W-1:0]  wrapped_phase;
   logic signed [psgu_pkg::FLOOR_W-1:0] floor_index;
   logic signed [psgu_pkg::UNW_W-1:0]   unwrapped_phase;
   logic                                pixel_valid;

   psgu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_data     (req_tdata),
      .out_valid   (front_valid),
      .out_ready   (front_ready),
      .out_data    (front_data)
   );

   psgu_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (cordic_valid),
      .out_ready (cordic_ready),
      .out_data  (cordic_data)
   );

   psgu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (cordic_valid),
      .in_ready        (cordic_ready),
      .in_data         (cordic_data),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .wrapped_phase   (wrapped_phase),
      .floor_index     (floor_index),
      .unwrapped_phase (unwrapped_phase),
      .pixel_valid     (pixel_valid)
   );

   // Pack the result fields, lowest field first
   assign rsp_tdata = {{(psgu_pkg::RSP_DATA_W - psgu_pkg::RSP_FIELDS_W){1'b0}},
                       pixel_valid, unwrapped_phase, floor_index, wrapped_phase};

endmodule

// ----- sv/psgu_checker.sv -----
// Port-level checks on the phase unwrap pipeline, bound to the top level
`include "phase_shift_graycode_unwrap_macros.svh"

module psgu_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [psgu_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // Hold a stalled result
   `PSGU_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // Drop the absolute phase of a dim pixel to zero
   `PSGU_ASSERT_IMP(a_dim_zero, clock, reset, rsp_tvalid && !rsp_tdata[43], rsp_tdata[42:22] == '0, "dim pixel has nonzero unwrapped phase")

   // Keep the wrapped phase within plus or minus pi
   `PSGU_ASSERT_IMP(a_phase_range, clock, reset, rsp_tvalid, ($signed(rsp_tdata[14:0]) <= psgu_pkg::PI_F) && ($signed(rsp_tdata[14:0]) >= -psgu_pkg::PI_F), "wrapped phase out of range")

   // Keep the fringe order between minus one and the top code
   `PSGU_ASSERT_IMP(a_floor_range, clock, reset, rsp_tvalid, ($signed(rsp_tdata[21:15]) >= psgu_pkg::FLOOR_MIN) && ($signed(rsp_tdata[21:15]) <= psgu_pkg::FLOOR_MAX), "fringe order out of range")

endmodule

bind phase_shift_graycode_unwrap psgu_checker u_psgu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/sv/phase_shift_graycode_unwrap_tb.sv -----
// Self-checking testbench for the phase shift gray-code unwrap pipeline
`timescale 1ns / 100ps

module phase_shift_graycode_unwrap_tb;

   localparam int          TIMEOUT_CYCLES = 1000000;
   localparam int          DRAIN_CYCLES   = 64;
   localparam int          RANDOM_PHASES  = 6;
   localparam int          PHASE_PIXELS   = 250;
   localparam int          ROUND_BITS     = 8;
   localparam longint      PI_Q20         = 3294199;
   localparam longint      HALF_PI_Q20    = 1647099;
   localparam longint      TWO_PI_Q20     = 6588397;
   localparam longint      PI_FIX         = (PI_Q20 + 128) >>> ROUND_BITS;
   localparam longint      HALF_PI_FIX    = (HALF_PI_Q20 + 128) >>> ROUND_BITS;
   localparam longint      TWO_PI_FIX     = (TWO_PI_Q20 + 128) >>> ROUND_BITS;
   localparam logic [7:0]  THRESHOLD_RESET = 8'd5;

   // One pixel as it travels on req_tdata, phase_sample_0 in the lowest byte
   typedef struct packed {
      logic [5:0][7:0] gray;
      logic [3:0][7:0] phase;
   } pixel_type;

   // One result as it travels on rsp_tdata, wrapped_phase in the lowest bits
   typedef struct packed {
      logic               pixel_valid;
      logic signed [20:0] unwrapped_phase;
      logic signed [6:0]  floor_index;
      logic signed [14:0] wrapped_phase;
   } unwrap_result_type;

   typedef struct {
      pixel_type         px;
      bit                typed;
      unwrap_result_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [psgu_pkg::SAMPLE_W-1:0] csr_wr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [psgu_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [psgu_pkg::RSP_DATA_W-1:0] rsp_tdata;

   unwrap_result_type expected_results[$];
   directed_row_type  directed_rows[$];
   logic [7:0]        threshold_model = THRESHOLD_RESET;
   int                mismatch_count = 0;
   int unsigned       cycle_count = 0;
   bit                sender_steady = 1'b0;
   bit                receiver_steady = 1'b0;
   int                stall_left = 0;
   unwrap_result_type got_result, want_result;

   phase_shift_graycode_unwrap dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Arctangent of 2^-step in Q20
   function automatic longint arctan_q20(int step);
      case (step)
         0: return 823550;
         1: return 486170;
         2: return 256879;
         3: return 130396;
         4: return 65451;
         5: return 32757;
         6: return 16383;
         7: return 8192;
         8: return 4096;
         9: return 2048;
         10: return 1024;
         11: return 512;
         12: return 256;
         13: return 128;
         14: return 64;
         15: return 32;
         16: return 16;
         17: return 8;
         18: return 4;
         default: return 2;
      endcase
   endfunction

   // Compute the result of one pixel under the given confidence threshold
   function automatic unwrap_result_type predict_unwrap(pixel_type px, logic [7:0] thr);
      longint sum, m, d, x, y, z, dx, dy, theta, phase, floor_v, k1, k2, unw;
      logic gray_bit;
      bit valid;
      int k;
      unwrap_result_type r;
      sum = 0;
      for (k = 0; k < 4; k++) sum += longint'(px.phase[k]);
      m = longint'(px.phase[1]) - longint'(px.phase[3]);
      d = longint'(px.phase[0]) - longint'(px.phase[2]);
      z = 0;
      // Vectoring rotations; a zero vector leaves the angle at zero
      if (m != 0 || d != 0) begin
         x = d * 64'sd16777216;
         y = m * 64'sd16777216;
         if (x < 0) begin
            z = (m >= 0) ? PI_Q20 : -PI_Q20;
            x = -x;
            y = -y;
         end
         for (k = 0; k < 20; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y >= 0) begin
               x += dx;
               y -= dy;
               z += arctan_q20(k);
            end else begin
               x -= dx;
               y += dy;
               z -= arctan_q20(k);
            end
         end
      end
      // Round to 12 fraction bits, ties upward, then clamp and negate
      theta = (z + 128) >>> ROUND_BITS;
      if (theta > PI_FIX) theta = PI_FIX;
      if (theta < -PI_FIX) theta = -PI_FIX;
      phase = -theta;
      // Threshold gray samples against the mean and decode by running XOR
      gray_bit = 1'b0;
      k1 = 0;
      k2 = 0;
      for (k = 0; k < 6; k++) begin
         gray_bit ^= (longint'(px.gray[k]) * 4 > sum);
         if (k != 5) k1 = k1 * 2 + longint'(gray_bit);
         k2 = k2 * 2 + longint'(gray_bit);
      end
      k2 = (k2 + 1) / 2;
      if (phase <= -HALF_PI_FIX) floor_v = k2;
      else if (phase >= HALF_PI_FIX) floor_v = k2 - 1;
      else floor_v = k1;
      valid = sum > 4 * longint'(thr);
      unw = valid ? phase + floor_v * TWO_PI_FIX + PI_FIX : 0;
      r.wrapped_phase   = phase[14:0];
      r.floor_index     = floor_v[6:0];
      r.unwrapped_phase = unw[20:0];
      r.pixel_valid     = valid;
      return r;
   endfunction

   function automatic pixel_type make_pixel(logic [7:0] s0, s1, s2, s3,
                                            logic [7:0] g0, g1, g2, g3, g4, g5);
      pixel_type px;
      px.phase = {s3, s2, s1, s0};
      px.gray  = {g5, g4, g3, g2, g1, g0};
      return px;
   endfunction

   function automatic logic [7:0] clamp_byte(int v);
      return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
   endfunction

   // Pick a byte at one of the two rails
   function automatic logic [7:0] rail_byte();
      if ($urandom_range(0, 1) == 1)
         return 8'(254 + $urandom_range(0, 1));
      return 8'($urandom_range(0, 1));
   endfunction

   // Random pixel, mostly aimed at decision boundaries of the datapath
   function automatic pixel_type random_pixel(logic [7:0] thr);
      pixel_type px;
      int kind, base, mean, k;
      bit near_mean;
      kind = $urandom_range(0, 9);
      near_mean = 1'b0;
      for (k = 0; k < 4; k++) px.phase[k] = 8'($urandom_range(0, 255));
      for (k = 0; k < 6; k++) px.gray[k] = 8'($urandom_range(0, 255));
      case (kind)
         4, 5: begin
            near_mean = 1'b1;
         end
         6: begin
            // zero vector on one or both axes
            if ($urandom_range(0, 2) != 0) px.phase[2] = px.phase[0];
            if ($urandom_range(0, 2) != 0) px.phase[3] = px.phase[1];
         end
         7: begin
            // small differences land near the axes and the half-pi boundaries
            base = $urandom_range(3, 252);
            for (k = 0; k < 4; k++)
               px.phase[k] = clamp_byte(base + int'($urandom_range(0, 6)) - 3);
            near_mean = 1'b1;
         end
         8: begin
            // mean right at the confidence threshold
            for (k = 0; k < 4; k++)
               px.phase[k] = clamp_byte(int'(thr) + int'($urandom_range(0, 2)) - 1);
            near_mean = ($urandom_range(0, 1) == 1);
         end
         9: begin
            for (k = 0; k < 4; k++) px.phase[k] = rail_byte();
            for (k = 0; k < 6; k++) px.gray[k] = rail_byte();
         end
         default: ;
      endcase
      if (near_mean) begin
         mean = (int'(px.phase[0]) + int'(px.phase[1]) + int'(px.phase[2]) +
                 int'(px.phase[3])) / 4;
         for (k = 0; k < 6; k++) px.gray[k] = clamp_byte(mean + int'($urandom_range(0, 2)) - 1);
      end
      return px;
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic add_row(pixel_type px, bit typed, unwrap_result_type want);
      directed_row_type row;
      row.px    = px;
      row.typed = typed;
      row.want  = want;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Offer one pixel, hold it until the transfer, then queue its result
   task automatic send_pixel(pixel_type px, bit typed, unwrap_result_type want);
      int gap;
      gap = sender_steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      expected_results.insert(expected_results.size(),
                              typed ? want : predict_unwrap(px, threshold_model));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      threshold_model = value;
   endtask

   task automatic log_mismatch(string what, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
   endtask

   // Result side: random stalls, with stretches of steady ready
   always @(posedge clock) begin
      if (cycle_count[7:0] == 8'd0) receiver_steady <= ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!receiver_steady && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= idle_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each result transfer with the oldest pending prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_result = rsp_tdata[43:0];
         if (expected_results.size() == 0) begin
            log_mismatch("result with none pending", 0, longint'(rsp_tdata[43:0]));
         end else begin
            want_result = expected_results.pop_front();
            if (got_result.wrapped_phase !== want_result.wrapped_phase)
               log_mismatch("wrapped_phase", want_result.wrapped_phase,
                            got_result.wrapped_phase);
            if (got_result.floor_index !== want_result.floor_index)
               log_mismatch("floor_index", want_result.floor_index, got_result.floor_index);
            if (got_result.unwrapped_phase !== want_result.unwrapped_phase)
               log_mismatch("unwrapped_phase", want_result.unwrapped_phase,
                            got_result.unwrapped_phase);
            if (got_result.pixel_valid !== want_result.pixel_valid)
               log_mismatch("pixel_valid", want_result.pixel_valid, got_result.pixel_valid);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("phase_shift_graycode_unwrap regression: fail");
         $finish;
      end
   end

   initial begin
      logic [7:0] thr;
      int p, n;
      // Typed rows: zero pixel, saturated pixel, just below and just above confidence
      add_row(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, {1'b0, 21'sd0, 7'sd0, 15'sd0});
      add_row(make_pixel(255, 255, 255, 255, 255, 255, 255, 255, 255, 255), 1'b1,
              {1'b1, 21'sd12868, 7'sd0, 15'sd0});
      add_row(make_pixel(5, 5, 5, 5, 255, 255, 255, 255, 255, 255), 1'b1,
              {1'b0, 21'sd0, 7'sd21, 15'sd0});
      add_row(make_pixel(6, 6, 6, 6, 255, 255, 255, 255, 255, 255), 1'b1,
              {1'b1, 21'sd553324, 7'sd21, 15'sd0});
      // Gray samples exactly at and one above the mean
      add_row(make_pixel(6, 6, 6, 6, 6, 6, 6, 6, 6, 6), 1'b0, '0);
      add_row(make_pixel(6, 6, 6, 6, 7, 7, 7, 7, 7, 7), 1'b0, '0);
      // Axis directions and the branch cut near +-pi
      add_row(make_pixel(255, 0, 0, 0, 128, 0, 255, 3, 64, 200), 1'b0, '0);
      add_row(make_pixel(0, 0, 255, 0, 255, 0, 255, 0, 255, 0), 1'b0, '0);
      add_row(make_pixel(0, 0, 255, 1, 0, 255, 0, 255, 0, 255), 1'b0, '0);
      add_row(make_pixel(0, 255, 0, 0, 200, 10, 90, 70, 30, 250), 1'b0, '0);
      add_row(make_pixel(0, 0, 0, 255, 10, 200, 70, 90, 250, 30), 1'b0, '0);
      // Highest fringe order and the order below zero
      add_row(make_pixel(0, 255, 255, 0, 255, 0, 0, 0, 0, 0), 1'b0, '0);
      add_row(make_pixel(0, 0, 255, 255, 0, 0, 0, 0, 0, 0), 1'b0, '0);
      // Nonzero zero vector, diagonals and half-pi neighbors
      add_row(make_pixel(128, 128, 128, 128, 129, 127, 128, 200, 1, 255), 1'b0, '0);
      add_row(make_pixel(255, 255, 0, 0, 170, 85, 170, 85, 170, 85), 1'b0, '0);
      add_row(make_pixel(1, 255, 0, 0, 0, 255, 255, 255, 255, 255), 1'b0, '0);
      add_row(make_pixel(0, 255, 1, 0, 255, 255, 255, 255, 255, 0), 1'b0, '0);
      add_row(make_pixel(1, 0, 0, 255, 255, 0, 255, 255, 0, 255), 1'b0, '0);
      add_row(make_pixel(0, 0, 1, 255, 0, 0, 255, 0, 0, 255), 1'b0, '0);

      // Hold reset, then release
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows under the reset threshold
      foreach (directed_rows[i])
         send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
      wait_idle();

      // Random phases, each under its own threshold
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: thr = 8'd0;
            1: thr = 8'd255;
            4: thr = 8'd1;
            default: thr = 8'($urandom_range(2, 254));
         endcase
         write_threshold(thr);
         sender_steady = (p % 3 == 2);
         for (n = 0; n < PHASE_PIXELS; n++)
            send_pixel(random_pixel(threshold_model), 1'b0, '0);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         log_mismatch("missing results", expected_results.size(), 0);
      if (mismatch_count == 0) begin
         $display("phase_shift_graycode_unwrap regression: pass");
      end else begin
         $display("phase_shift_graycode_unwrap regression: fail");
      end
      $finish;
   end

endmodule
